// ===== src/fgnh_pkg.sv =====
// shared constants for the four-octave gradient noise height generator
// no dependencies
`default_nettype none
package fgnh_pkg;
  localparam int COORD_W    = 24;
  localparam int GRAD_W     = 16;
  localparam int IDX_W      = 10;
  localparam int HEIGHT_W   = 18;
  localparam int OCTAVES    = 4;
  localparam int CORNERS    = 4 * OCTAVES;
  localparam int ROW_MUL    = 41;
  localparam int COL_MUL    = 43;
  localparam int HASH_W     = 19;
  localparam int HEIGHT_MAX = 131071;
  localparam int HEIGHT_MIN = -131072;
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_EVAL  = 1'b1;
endpackage
`default_nettype wire

// ===== src/fractal_gradient_noise_height_top.sv =====
// Gradient noise height generator. Takes one word per clock while not stalled,
// either a gradient table load or a coordinate to evaluate. Depends on fgnh_pkg.
//
// One word is accepted every cycle unless in_stall is high; the pipeline holds
// whenever a finished result waits on a stalled output. Gradient lookups run on 16
// copies of the table, one per octave corner, all written together, so all 16 reads
// happen in the same cycle. A load takes effect at the table stage, so every later
// evaluate sees it. Loads give no result. Reading a table entry that was never
// written gives an undefined height.
`default_nettype none
module fractal_gradient_noise_height_top #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic opcode,
  input  logic [fgnh_pkg::IDX_W-1:0] table_index,
  input  logic signed [fgnh_pkg::GRAD_W-1:0] grad_x,
  input  logic signed [fgnh_pkg::GRAD_W-1:0] grad_y,
  input  logic signed [fgnh_pkg::COORD_W-1:0] coord_x,
  input  logic signed [fgnh_pkg::COORD_W-1:0] coord_y,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [fgnh_pkg::HEIGHT_W-1:0] height
);
  import fgnh_pkg::*;

  localparam int IW    = $clog2(TABLE_DEPTH);
  localparam int RECIP = (1 << HASH_W) / TABLE_DEPTH;
  localparam int HOFF  = TABLE_DEPTH * (((1 << 18) + TABLE_DEPTH - 1) / TABLE_DEPTH);

  logic en;
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 1: input word
  logic v1, op1;
  logic [IDX_W-1:0] idx1;
  logic [2*GRAD_W-1:0] gd1;
  logic signed [COORD_W-1:0] cx1, cy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      op1 <= opcode;
      idx1 <= table_index;
      gd1 <= {grad_y, grad_x};
      cx1 <= coord_x;
      cy1 <= coord_y;
    end
  end

  // stage 2: grid cell, fraction, biased hash
  logic signed [20:0] rx_c [OCTAVES];
  logic signed [20:0] ry_c [OCTAVES];
  logic [15:0] fr_c [2*OCTAVES];
  logic [HASH_W-1:0] u_c [CORNERS];

  always_comb begin
    for (int o = 0; o < OCTAVES; o++) begin
      rx_c[o] = 21'(cx1 >>> (15 - o));
      ry_c[o] = 21'(cy1 >>> (15 - o));
      fr_c[2*o] = 16'(cx1 << (o + 1));
      fr_c[2*o+1] = 16'(cy1 << (o + 1));
      for (int c = 0; c < 4; c++) begin
        u_c[4*o+c] = HASH_W'((int'(rx_c[o]) + (c & 1)) * ROW_MUL +
                             (int'(ry_c[o]) + (c >> 1)) * COL_MUL + HOFF);
      end
    end
  end

  logic v2, op2;
  logic [IDX_W-1:0] idx2;
  logic [2*GRAD_W-1:0] gd2;
  logic [HASH_W-1:0] u2 [CORNERS];
  logic [15:0] fr2 [2*OCTAVES];

  // stage 3: quotient estimate, fraction squared
  logic v3, op3;
  logic [IDX_W-1:0] idx3;
  logic [2*GRAD_W-1:0] gd3;
  logic [HASH_W-1:0] u3 [CORNERS];
  logic [15:0] q3 [CORNERS];
  logic [15:0] fr3 [2*OCTAVES];
  logic [31:0] sq3 [2*OCTAVES];
  logic [34:0] prod_c [CORNERS];

  always_comb begin
    for (int i = 0; i < CORNERS; i++) begin
      prod_c[i] = 35'(u2[i]) * 35'(RECIP);
    end
  end

  // stage 4: remainder within twice the depth, fraction cubed
  logic v4, op4;
  logic [IDX_W-1:0] idx4;
  logic [2*GRAD_W-1:0] gd4;
  logic [IW:0] r4 [CORNERS];
  logic [15:0] fr4 [2*OCTAVES];
  logic [31:0] sq4 [2*OCTAVES];
  logic [47:0] cu4 [2*OCTAVES];

  // stage 5: table read and easing weight
  logic v5;
  logic [IW-1:0] addr_c [CORNERS];
  logic [2*GRAD_W-1:0] rd5 [CORNERS];
  logic [15:0] fr5 [2*OCTAVES];
  logic [16:0] w5 [2*OCTAVES];
  logic [50:0] ez_c [2*OCTAVES];
  logic wr_en;
  logic addr_ok, w_ok;

  always_comb begin
    addr_ok = 1'b1;
    for (int i = 0; i < CORNERS; i++) begin
      if (r4[i] >= (IW+1)'(TABLE_DEPTH)) begin
        addr_c[i] = IW'(r4[i] - (IW+1)'(TABLE_DEPTH));
      end else begin
        addr_c[i] = IW'(r4[i]);
      end
      if (32'(addr_c[i]) >= 32'(TABLE_DEPTH)) begin
        addr_ok = 1'b0;
      end
    end
    for (int j = 0; j < 2*OCTAVES; j++) begin
      ez_c[j] = 51'(3) * (51'(sq4[j]) << 16) - 51'(2) * 51'(cu4[j]) + (51'(1) << 31);
    end
    w_ok = 1'b1;
    for (int j = 0; j < 2*OCTAVES; j++) begin
      if (w5[j] > 17'h10000) begin
        w_ok = 1'b0;
      end
    end
  end

  assign wr_en = v4 && (op4 == OP_LOAD) && (32'(idx4) < 32'(TABLE_DEPTH));

  for (genvar i = 0; i < CORNERS; i++) begin : g_copy
    logic [2*GRAD_W-1:0] mem [TABLE_DEPTH];
    logic [2*GRAD_W-1:0] rd;
    always_ff @(posedge clk) begin
      if (en && wr_en) begin
        mem[IW'(idx4)] <= gd4;
      end
      if (en) begin
        rd <= mem[addr_c[i]];
      end
    end
    assign rd5[i] = rd;
  end

  // stage 6: gradient times offset
  logic v6;
  logic signed [16:0] ox_c [CORNERS];
  logic signed [16:0] oy_c [CORNERS];
  logic signed [32:0] px6 [CORNERS];
  logic signed [32:0] py6 [CORNERS];
  logic [16:0] w6 [2*OCTAVES];

  always_comb begin
    for (int o = 0; o < OCTAVES; o++) begin
      for (int c = 0; c < 4; c++) begin
        ox_c[4*o+c] = $signed({1'(c & 1), fr5[2*o]});
        oy_c[4*o+c] = $signed({1'(c >> 1), fr5[2*o+1]});
      end
    end
  end

  // stage 7: rounded dot products
  logic v7;
  logic signed [19:0] d7 [CORNERS];
  logic [16:0] w7 [2*OCTAVES];

  // stage 8/9: blend along x
  logic v8;
  logic signed [38:0] pg8 [OCTAVES];
  logic signed [38:0] ph8 [OCTAVES];
  logic signed [19:0] tl8 [OCTAVES];
  logic signed [19:0] bl8 [OCTAVES];
  logic [16:0] wy8 [OCTAVES];
  logic v9;
  logic signed [20:0] g9 [OCTAVES];
  logic signed [20:0] h9 [OCTAVES];
  logic [16:0] wy9 [OCTAVES];

  // stage 10/11: blend along y
  logic v10;
  logic signed [39:0] pn10 [OCTAVES];
  logic signed [20:0] g10 [OCTAVES];
  logic v11;
  logic signed [21:0] n11 [OCTAVES];

  // stage 12: octave sum and saturation
  logic signed [25:0] sum_c, rnd_c;
  logic signed [HEIGHT_W-1:0] sat_c;

  always_comb begin
    sum_c = (26'(n11[0]) <<< 3) + (26'(n11[1]) <<< 2) + (26'(n11[2]) <<< 1) + 26'(n11[3]);
    rnd_c = (sum_c + 26'sd8) >>> 4;
    if (rnd_c > 26'(HEIGHT_MAX)) begin
      sat_c = HEIGHT_W'(HEIGHT_MAX);
    end else if (rnd_c < 26'(HEIGHT_MIN)) begin
      sat_c = HEIGHT_W'(HEIGHT_MIN);
    end else begin
      sat_c = HEIGHT_W'(rnd_c);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
      v9 <= 1'b0;
      v10 <= 1'b0;
      v11 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4 && (op4 != OP_LOAD);
      v6 <= v5;
      v7 <= v6;
      v8 <= v7;
      v9 <= v8;
      v10 <= v9;
      v11 <= v10;
      out_valid <= v11;
    end
    if (en) begin
      op2 <= op1;
      idx2 <= idx1;
      gd2 <= gd1;
      op3 <= op2;
      idx3 <= idx2;
      gd3 <= gd2;
      op4 <= op3;
      idx4 <= idx3;
      gd4 <= gd3;
      for (int i = 0; i < CORNERS; i++) begin
        u2[i] <= u_c[i];
        u3[i] <= u2[i];
        q3[i] <= prod_c[i][34:19];
        r4[i] <= (IW+1)'(34'(u3[i]) - 34'(q3[i]) * 34'(TABLE_DEPTH));
        px6[i] <= 33'($signed(rd5[i][15:0])) * 33'(ox_c[i]);
        py6[i] <= 33'($signed(rd5[i][31:16])) * 33'(oy_c[i]);
        d7[i] <= 20'((34'(px6[i]) + 34'(py6[i]) + 34'sd8192) >>> 14);
      end
      for (int j = 0; j < 2*OCTAVES; j++) begin
        fr2[j] <= fr_c[j];
        fr3[j] <= fr2[j];
        sq3[j] <= 32'(fr2[j]) * 32'(fr2[j]);
        fr4[j] <= fr3[j];
        sq4[j] <= sq3[j];
        cu4[j] <= 48'(sq3[j]) * 48'(fr3[j]);
        fr5[j] <= fr4[j];
        w5[j] <= ez_c[j][48:32];
        w6[j] <= w5[j];
        w7[j] <= w6[j];
      end
      for (int o = 0; o < OCTAVES; o++) begin
        pg8[o] <= (39'(d7[4*o+1]) - 39'(d7[4*o])) * 39'($signed({1'b0, w7[2*o]}));
        ph8[o] <= (39'(d7[4*o+3]) - 39'(d7[4*o+2])) * 39'($signed({1'b0, w7[2*o]}));
        tl8[o] <= d7[4*o];
        bl8[o] <= d7[4*o+2];
        wy8[o] <= w7[2*o+1];
        g9[o] <= 21'(39'(tl8[o]) + ((pg8[o] + 39'sd32768) >>> 16));
        h9[o] <= 21'(39'(bl8[o]) + ((ph8[o] + 39'sd32768) >>> 16));
        wy9[o] <= wy8[o];
        pn10[o] <= (40'(h9[o]) - 40'(g9[o])) * 40'($signed({1'b0, wy9[o]}));
        g10[o] <= g9[o];
        n11[o] <= 22'(40'(g10[o]) + ((pn10[o] + 40'sd32768) >>> 16));
      end
      height <= sat_c;
    end
  end

  // hash reduction lands inside the table
  a_addr_range: assert property (@(posedge clk) disable iff (rst) v4 |-> addr_ok)
    else $error("table address out of range");

  // easing weight never exceeds one
  a_weight_range: assert property (@(posedge clk) disable iff (rst) v5 |-> w_ok)
    else $error("easing weight above one");

  // a load word leaves the pipeline at the table stage
  a_load_drops: assert property (@(posedge clk) disable iff (rst)
    (en && v4 && (op4 == OP_LOAD)) |=> !v5)
    else $error("load word passed the table stage");

  // a held pipeline keeps its finished result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> out_valid && $stable(height))
    else $error("result lost while pipeline held");

endmodule
`default_nettype wire
